### hdl/svvt_pkg.sv
// shared constants and types for the sparse version vector table
package svvt_pkg;

   // table geometry
   localparam int ENTRIES = 64;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int REP_W   = 16;
   localparam int VAL_W   = 32;
   localparam int DENSE_W = REP_W + 1;
   localparam int OUT_CNT_W = 7;

   // command codes
   localparam logic [1:0] CMD_OBSERVE = 2'd0;
   localparam logic [1:0] CMD_MEET    = 2'd1;
   localparam logic [1:0] CMD_QUERY   = 2'd2;

   // response word layout
   localparam int RSP_W = 64;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic look;
      logic commit;
   } ctrl_cmd_type;

endpackage

### hdl/sparse_version_vector_table.sv
// top level of the sparse version vector table
//
// Holds up to 64 (replica, counter) pairs sorted by replica in a row of
// cells. Request words arrive on req_*: tuser carries the command
// (observe, meet, query), tdata the replica and counter value. Each
// request yields exactly one response word on rsp_*, in order.
// A request is taken into the held-item registers, compared against all
// cells in the look state, then shifted/updated in the update state,
// where its response word is registered on commit; the next request is
// taken in the same cycle the previous one commits.
// The response sits in an output register; while the receiver stalls a
// further request can be taken and compared, and it commits once the
// waiting word is taken. Reset empties the table at once (count and
// dense length cleared); no clearing pass is needed.
module sparse_version_vector_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // replica[15:0], counter_value[47:16]
   input  logic [1:0]  req_tuser,  // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // stored_value[31:0], present[32], covered[33],
                                   // full_refused[34], dense_length[51:35],
                                   // entry_count[58:52], zero[63:59]
);
   import svvt_pkg::*;

   ctrl_cmd_type cmd;

   svvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   svvt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .item_cmd (req_tuser),
      .item_rep (req_tdata[REP_W-1:0]),
      .item_val (req_tdata[REP_W +: VAL_W]),
      .rsp_word (rsp_tdata)
   );

endmodule

### hdl/svvt_ctrl.sv
// controller state machine: sequences lookup, update and response handoff
module svvt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output svvt_pkg::ctrl_cmd_type cmd
);
   import svvt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register may take a new word when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_UPDATE) && out_free);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.look   = (state_ff == ST_LOOK);
   assign cmd.commit = (state_ff == ST_UPDATE) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (cmd.commit) state_in = cmd.load ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);
   end

   // state and registered valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/svvt_datapath.sv
// datapath: row of sorted pair cells, compare vectors and response register
module svvt_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  svvt_pkg::ctrl_cmd_type     cmd,
   input  logic [1:0]                 item_cmd,
   input  logic [svvt_pkg::REP_W-1:0] item_rep,
   input  logic [svvt_pkg::VAL_W-1:0] item_val,
   output logic [svvt_pkg::RSP_W-1:0] rsp_word
);
   import svvt_pkg::*;

   // pair cells
   logic [REP_W-1:0]   rep_ff [ENTRIES];
   logic [VAL_W-1:0]   val_ff [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DENSE_W-1:0] dense_ff, dense_in;

   // held item
   logic [1:0]         cmd_ff;
   logic [REP_W-1:0]   irep_ff;
   logic [VAL_W-1:0]   ival_ff;

   // compare vectors
   logic [ENTRIES-1:0] lt_ff, lt_in;
   logic [ENTRIES-1:0] eq_ff, eq_in;

   logic [ENTRIES-1:0] is_pos;
   logic [ENTRIES-1:0] hit_vec;
   logic               hit;
   logic [VAL_W-1:0]   hit_val;
   logic               full;
   logic               is_obs;
   logic               ins;
   logic               refused;
   logic               raise;
   logic               lower;
   logic [VAL_W-1:0]   new_val;
   logic [VAL_W-1:0]   stored;
   logic               present;
   logic               covered;
   logic [RSP_W-1:0]   rsp_ff, rsp_in;

   // per-cell compare against the held replica
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         lt_in[k] = (CNT_W'(k) < count_ff) && (rep_ff[k] < irep_ff);
         eq_in[k] = (CNT_W'(k) < count_ff) && (rep_ff[k] == irep_ff);
      end
   end

   // insertion point, hit and hit value
   always_comb begin
      hit_val = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         if (k == 0) is_pos[k] = !lt_ff[k];
         else        is_pos[k] = !lt_ff[k] && lt_ff[k-1];
         hit_vec[k] = is_pos[k] && eq_ff[k];
         hit_val    = hit_val | (val_ff[k] & {VAL_W{hit_vec[k]}});
      end
      hit = |hit_vec;
   end

   // command decision
   always_comb begin
      full    = (count_ff == CNT_W'(ENTRIES));
      is_obs  = (cmd_ff == CMD_OBSERVE) && (ival_ff != '0);
      ins     = is_obs && !hit && !full;
      refused = is_obs && !hit && full;
      raise   = is_obs && hit && (hit_val < ival_ff);
      lower   = (cmd_ff == CMD_MEET) && hit && (ival_ff != '0) && (ival_ff < hit_val);
      new_val = (raise || lower) ? ival_ff : hit_val;
      if (hit)      stored = new_val;
      else if (ins) stored = ival_ff;
      else          stored = '0;
      present  = hit || ins;
      covered  = (stored >= ival_ff);
      count_in = ins ? count_ff + CNT_W'(1) : count_ff;
      // a new replica at or past the dense length lands at the end
      if (ins && ({1'b0, irep_ff} >= dense_ff)) dense_in = {1'b0, irep_ff} + DENSE_W'(1);
      else                                      dense_in = dense_ff;
      rsp_in = '0;
      rsp_in[VAL_W-1:0]                             = stored;
      rsp_in[VAL_W]                                 = present;
      rsp_in[VAL_W+1]                               = covered;
      rsp_in[VAL_W+2]                               = refused;
      rsp_in[VAL_W+3 +: DENSE_W]                    = dense_in;
      rsp_in[VAL_W+3+DENSE_W +: OUT_CNT_W]          = OUT_CNT_W'(count_in);
   end

   // cell update: shift up above the insertion point, write or modify in place
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int k = 0; k < ENTRIES; k++) begin
            if (ins && is_pos[k]) begin
               rep_ff[k] <= irep_ff;
               val_ff[k] <= ival_ff;
            end else if (ins && (k > 0) && !lt_ff[(k > 0) ? k-1 : 0]) begin
               rep_ff[k] <= rep_ff[(k > 0) ? k-1 : 0];
               val_ff[k] <= val_ff[(k > 0) ? k-1 : 0];
            end else if ((raise || lower) && hit_vec[k]) begin
               val_ff[k] <= ival_ff;
            end
         end
      end
   end

   // held item, compare vectors and response word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= item_cmd;
         irep_ff <= item_rep;
         ival_ff <= item_val;
      end
      if (cmd.look) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   // table occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dense_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         dense_ff <= dense_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

### hdl/svvt_checker.sv
// port-level checker for the sparse version vector table, with its bind
module svvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   import svvt_pkg::*;

   // a stalled response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word dropped or changed under stall");

   // a present replica never holds a zero counter
   a_present_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] != 32'd0)
      else $error("present replica with zero counter");

   // a refused insert only happens on a full table and leaves nothing present
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |-> !rsp_tdata[32] && rsp_tdata[58:52] == 7'(ENTRIES))
      else $error("refused insert on a table that is not full");

   // dense length is zero exactly when the table is empty
   a_dense_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[51:35] == 17'd0) == (rsp_tdata[58:52] == 7'd0)))
      else $error("dense length disagrees with entry count");

endmodule

bind sparse_version_vector_table svvt_checker u_svvt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
